/* design/frp_pkg.sv */
package frp_pkg;

  // default sizes and register reset
  localparam int HEADER_MAX_DEF = 199;
  localparam int COUNT_BITS_DEF = 16;
  localparam logic [15:0] MAX_RESIDUES_RESET = 16'd40000;

  // character codes
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_LEAD,
    PH_ID,
    PH_DESC,
    PH_SEQ
  } phase_t;

  typedef enum logic [2:0] {
    KIND_ID,
    KIND_DESC,
    KIND_RES,
    KIND_END,
    KIND_SKIP,
    KIND_LONG
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_value;
    logic [15:0] residue_count;
    logic        record_last;
  } result_t;

endpackage

/* design/frp_if.sv */
interface frp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface frp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  char_value;
  logic [15:0] residue_count;
  logic        record_last;

  modport source (output valid, output kind, output char_value, output residue_count,
                  output record_last, input ready);
  modport sink (input valid, input kind, input char_value, input residue_count,
                input record_last, output ready);
endinterface

interface frp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/frp_step.sv */
module frp_step #(
  parameter int HEADER_MAX = frp_pkg::HEADER_MAX_DEF,
  parameter int COUNT_BITS = frp_pkg::COUNT_BITS_DEF
) (
  input  frp_pkg::phase_t        phase,
  input  logic [7:0]             header_chars,
  input  logic [COUNT_BITS-1:0]  residue_total,
  input  logic [15:0]            max_residues,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_input,
  output frp_pkg::phase_t        phase_next,
  output logic [7:0]             header_chars_next,
  output logic [COUNT_BITS-1:0]  residue_total_next,
  output logic                   emit,
  output frp_pkg::result_t       result
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};
  localparam logic [7:0] HDR_KEEP = 8'(HEADER_MAX);

  logic                  keep;
  logic                  hdr_space;
  logic                  seq_space;
  logic                  is_lower;
  logic                  is_letter;
  logic [7:0]            upper;
  logic [COUNT_BITS-1:0] inc;
  logic [CMP_W-1:0]      inc_ext;
  logic [CMP_W-1:0]      total_ext;
  logic                  too_long;

  always_comb begin
    keep      = header_chars < HDR_KEEP;
    hdr_space = (data_byte == frp_pkg::CH_SP) || (data_byte == frp_pkg::CH_TAB) ||
                (data_byte == frp_pkg::CH_LF) || (data_byte == frp_pkg::CH_VT) ||
                (data_byte == frp_pkg::CH_FF) || (data_byte == frp_pkg::CH_CR);
    seq_space = (data_byte == frp_pkg::CH_SP) || (data_byte == frp_pkg::CH_TAB) ||
                (data_byte == frp_pkg::CH_LF) || (data_byte == frp_pkg::CH_CR);
    is_lower  = (data_byte >= frp_pkg::CH_LOWER_A) && (data_byte <= frp_pkg::CH_LOWER_Z);
    upper     = is_lower ? (data_byte - frp_pkg::CASE_DIFF) : data_byte;
    is_letter = (upper >= frp_pkg::CH_UPPER_A) && (upper <= frp_pkg::CH_UPPER_Z);
    inc       = (residue_total < LIMIT) ? (residue_total + 1'b1) : residue_total;
    inc_ext   = CMP_W'(inc);
    total_ext = CMP_W'(residue_total);
    too_long  = (inc_ext >= CMP_W'(max_residues)) || (inc == LIMIT);
  end

  always_comb begin
    phase_next         = phase;
    header_chars_next  = header_chars;
    residue_total_next = residue_total;
    emit               = 1'b0;
    result.kind          = frp_pkg::KIND_ID;
    result.char_value    = data_byte;
    result.residue_count = '0;
    result.record_last   = 1'b0;

    if (end_of_input) begin
      // end of file closes an open record, seek stays silent
      phase_next         = frp_pkg::PH_SEEK;
      header_chars_next  = '0;
      residue_total_next = '0;
      if (phase != frp_pkg::PH_SEEK && phase <= frp_pkg::PH_SEQ) begin
        emit                 = 1'b1;
        result.kind          = frp_pkg::KIND_END;
        result.char_value    = '0;
        result.residue_count = (phase == frp_pkg::PH_SEQ) ? total_ext[15:0] : 16'd0;
        result.record_last   = 1'b1;
      end
    end else begin
      case (phase)
        frp_pkg::PH_LEAD, frp_pkg::PH_ID, frp_pkg::PH_DESC: begin
          if (header_chars != 8'hFF) begin
            header_chars_next = header_chars + 8'd1;
          end
          if (data_byte == frp_pkg::CH_LF) begin
            phase_next         = frp_pkg::PH_SEQ;
            residue_total_next = '0;
          end else if (phase == frp_pkg::PH_LEAD) begin
            if (!hdr_space) begin
              phase_next  = frp_pkg::PH_ID;
              emit        = keep;
              result.kind = frp_pkg::KIND_ID;
            end
          end else if (phase == frp_pkg::PH_ID) begin
            if (hdr_space) begin
              phase_next = frp_pkg::PH_DESC;
            end else begin
              emit        = keep;
              result.kind = frp_pkg::KIND_ID;
            end
          end else begin
            emit        = keep;
            result.kind = frp_pkg::KIND_DESC;
          end
        end
        frp_pkg::PH_SEQ: begin
          if (data_byte == frp_pkg::CH_GT) begin
            emit                 = 1'b1;
            result.kind          = frp_pkg::KIND_END;
            result.char_value    = '0;
            result.residue_count = total_ext[15:0];
            result.record_last   = 1'b1;
            residue_total_next   = '0;
            header_chars_next    = '0;
            phase_next           = frp_pkg::PH_LEAD;
          end else if (is_letter) begin
            emit                 = 1'b1;
            result.char_value    = upper;
            result.residue_count = inc_ext[15:0];
            if (too_long) begin
              result.kind        = frp_pkg::KIND_LONG;
              result.record_last = 1'b1;
              residue_total_next = '0;
              phase_next         = frp_pkg::PH_SEEK;
            end else begin
              result.kind        = frp_pkg::KIND_RES;
              residue_total_next = inc;
            end
          end else if (!seq_space) begin
            emit                 = 1'b1;
            result.kind          = frp_pkg::KIND_SKIP;
            result.residue_count = total_ext[15:0];
          end
        end
        default: begin
          // seek, and any stray phase code falls back to seek
          phase_next = frp_pkg::PH_SEEK;
          if (data_byte == frp_pkg::CH_GT) begin
            phase_next         = frp_pkg::PH_LEAD;
            header_chars_next  = '0;
            residue_total_next = '0;
          end
        end
      endcase
    end
  end

endmodule

/* design/fasta_record_parser_core.sv */
// fasta record parser: turns a fasta text stream into id, description,
// residue, skip, end and too-long items, at most one item per text byte.
// channels:
//   text   - sink, one item per byte: data_byte and end_of_input
//   result - source, at most one item per text item: kind, char_value,
//            residue_count, record_last
//   cfg    - sink, writes max_residues; always ready, write only while idle
// data path: a text item accepted goes into the input holding register, then
// through the step into the output register once that register is free.
// throughput: one text item per cycle unless result stalls; the state update
// is a single short pass between the input holding and output registers.
// reset (rst, synchronous): parser back to seeking '>', counts cleared,
// max_residues back to 40000, both holding registers empty.
// stall: when result is not taken the output register holds, the input
// register holds one more item, then text.ready drops.
module fasta_record_parser_core #(
  parameter int HEADER_MAX = frp_pkg::HEADER_MAX_DEF,
  parameter int COUNT_BITS = frp_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  frp_text_if.sink      text,
  frp_result_if.source  result,
  frp_cfg_if.sink       cfg
);

  // parser state
  frp_pkg::phase_t        phase;
  logic [7:0]             header_chars;
  logic [COUNT_BITS-1:0]  residue_total;
  logic [15:0]            max_residues;

  // input holding register
  logic                   hold_valid;
  logic [7:0]             hold_byte;
  logic                   hold_eof;

  // output register
  logic                   out_valid;
  frp_pkg::result_t       out_res;

  // step results
  frp_pkg::phase_t        phase_next;
  logic [7:0]             header_chars_next;
  logic [COUNT_BITS-1:0]  residue_total_next;
  logic                   step_emit;
  frp_pkg::result_t       step_res;

  logic                   step_fire;
  logic                   text_take;

  // the held byte advances when the output register is empty or drains now
  assign step_fire = hold_valid && (!out_valid || result.ready);
  assign text.ready = !hold_valid || step_fire;
  assign text_take = text.valid && text.ready;
  assign cfg.ready = 1'b1;

  frp_step #(
    .HEADER_MAX (HEADER_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .phase              (phase),
    .header_chars       (header_chars),
    .residue_total      (residue_total),
    .max_residues       (max_residues),
    .data_byte          (hold_byte),
    .end_of_input       (hold_eof),
    .phase_next         (phase_next),
    .header_chars_next  (header_chars_next),
    .residue_total_next (residue_total_next),
    .emit               (step_emit),
    .result             (step_res)
  );

  // control and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= frp_pkg::PH_SEEK;
      header_chars  <= '0;
      residue_total <= '0;
      max_residues  <= frp_pkg::MAX_RESIDUES_RESET;
    end else begin
      if (text_take) begin
        hold_valid <= 1'b1;
      end else if (step_fire) begin
        hold_valid <= 1'b0;
      end
      if (step_fire && step_emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (step_fire) begin
        phase         <= phase_next;
        header_chars  <= header_chars_next;
        residue_total <= residue_total_next;
      end
      if (cfg.valid) begin
        max_residues <= cfg.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (text_take) begin
      hold_byte <= text.data_byte;
      hold_eof  <= text.end_of_input;
    end
    if (step_fire && step_emit) begin
      out_res <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_res.kind;
  assign result.char_value    = out_res.char_value;
  assign result.residue_count = out_res.residue_count;
  assign result.record_last   = out_res.record_last;

  // only record end and too long close a record
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.record_last |->
      (out_res.kind == frp_pkg::KIND_END) || (out_res.kind == frp_pkg::KIND_LONG))
    else $error("record_last on a result that does not close a record");

  // end of input always returns the parser to seek
  a_eof_seek: assert property (@(posedge clk) disable iff (rst)
    step_fire && hold_eof |=> phase == frp_pkg::PH_SEEK)
    else $error("parser not in seek after end of input");

  // a produced result is never dropped
  a_emit_loaded: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_emit |=> out_valid)
    else $error("produced result not loaded into output register");

  // reset empties the output and restarts the parse
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !hold_valid && (phase == frp_pkg::PH_SEEK))
    else $error("state not cleared by reset");

endmodule
